>>> hw/rtl/ptsch_pkg.sv
`default_nettype none
package ptsch_pkg;

   localparam int DEPTH_DEFAULT = 32;
   localparam int MAX_RESULTS   = 32;

   // Request and response codes.
   localparam logic [1:0] REQ_ADD      = 2'd0;
   localparam logic [1:0] REQ_REMOVE   = 2'd1;
   localparam logic [1:0] REQ_TICK     = 2'd2;
   localparam logic [1:0] REQ_RESERVED = 2'd3;

   localparam logic [1:0] KIND_ADD    = 2'd0;
   localparam logic [1:0] KIND_REMOVE = 2'd1;
   localparam logic [1:0] KIND_TICK   = 2'd2;

   localparam logic [1:0] ST_OK        = 2'd0;
   localparam logic [1:0] ST_FULL      = 2'd1;
   localparam logic [1:0] ST_NOT_FOUND = 2'd2;
   localparam logic [1:0] ST_NONE_DUE  = 2'd3;

   typedef struct packed {
      logic [1:0]  req_type;
      logic [31:0] now;
      logic [15:0] repeat_total;
      logic [15:0] period;
      logic        first_now;
      logic [15:0] first_delay;
      logic [31:0] remove_id;
   } req_word_type;

   typedef struct packed {
      logic [1:0]  resp_kind;
      logic [1:0]  status;
      logic [31:0] timer_id;
      logic        last;
   } rsp_word_type;

   // One timer as held in a cell.
   typedef struct packed {
      logic [31:0] deadline;
      logic [31:0] id;
      logic [15:0] period;
      logic [15:0] total;
      logic [15:0] fired;
   } entry_type;

   typedef enum logic [1:0] {
      OP_HOLD,
      OP_INSERT,
      OP_SHIFT,
      OP_ROTATE
   } cell_op_type;

   typedef struct packed {
      cell_op_type op;
      entry_type   x;
   } cell_ctrl_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_ADD,
      S_REM,
      S_REM_RSP,
      S_TICK,
      S_REINS
   } state_type;

   // Deadline sum that sticks at the maximum time.
   function automatic logic [31:0] sat_add(input logic [31:0] a, input logic [15:0] b);
      logic [32:0] s;
      s = {1'b0, a} + {17'b0, b};
      return s[32] ? 32'hFFFF_FFFF : s[31:0];
   endfunction

endpackage
`default_nettype wire

>>> hw/rtl/ptsch_cell.sv
`default_nettype none
module ptsch_cell #(
   parameter int IDX   = 0,
   parameter int OCC_W = 6
) (
   input  wire                     clock,
   input  ptsch_pkg::cell_ctrl_type ctrl,
   input  wire  [OCC_W-1:0]        occupancy,
   input  ptsch_pkg::entry_type    left_entry,
   input  wire                     left_le,
   input  ptsch_pkg::entry_type    right_entry,
   input  ptsch_pkg::entry_type    front_entry,
   output ptsch_pkg::entry_type    entry,
   output logic                    le
);

   localparam logic [OCC_W-1:0] IDX_V  = OCC_W'(IDX);
   localparam logic [OCC_W-1:0] TAIL_V = OCC_W'(IDX + 1);

   ptsch_pkg::entry_type entry_ff, entry_in;
   logic valid, is_tail;

   // Occupied cells form a prefix of the row.
   assign valid   = IDX_V < occupancy;
   assign is_tail = occupancy == TAIL_V;
   assign le      = valid && (entry_ff.deadline <= ctrl.x.deadline);
   assign entry   = entry_ff;

   // Ordered insert moves the later part right; shift moves everything left; rotate moves the front to the tail.
   always_comb begin
      entry_in = entry_ff;
      case (ctrl.op)
         ptsch_pkg::OP_INSERT: begin
            if (!le) begin
               entry_in = left_le ? ctrl.x : left_entry;
            end
         end
         ptsch_pkg::OP_SHIFT:  entry_in = right_entry;
         ptsch_pkg::OP_ROTATE: entry_in = is_tail ? front_entry : right_entry;
         default:              entry_in = entry_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

endmodule
`default_nettype wire

>>> hw/rtl/periodic_timer_scheduler.sv
`default_nettype none
// Timer scheduler built as a row of DEPTH cells, one timer per cell, kept in
// deadline order with ties in insertion order. A request word is taken only
// when the controller is idle; a finished response word waits in an output
// register. A remove rotates the row once through its front cell to find the
// id, and a tick pops each fired timer, then reinserts it in order unless its
// repeat count is used up. A held-back response word stalls each step that
// must write a new one. A full store, missing id or empty tick still yields
// one response word.
module periodic_timer_scheduler #(
   parameter int DEPTH = ptsch_pkg::DEPTH_DEFAULT
) (
   input  wire                    clock,
   input  wire                    reset,
   input  wire                    req_valid,
   output logic                   req_ready,
   input  ptsch_pkg::req_word_type req_word,
   output logic                   rsp_valid,
   input  wire                    rsp_ready,
   output ptsch_pkg::rsp_word_type rsp_word
);

   localparam int OW = $clog2(DEPTH + 1);
   localparam int LW = $clog2(ptsch_pkg::MAX_RESULTS + 1);
   localparam int CW = (OW > LW) ? OW : LW;
   localparam logic [OW-1:0] DEPTH_V = OW'(DEPTH);
   localparam logic [CW-1:0] MAXR_V  = CW'(ptsch_pkg::MAX_RESULTS);

   ptsch_pkg::state_type     state_ff, state_in;
   ptsch_pkg::req_word_type  req_ff, req_in;
   ptsch_pkg::rsp_word_type  rsp_ff, rsp_in;
   ptsch_pkg::entry_type     pop_ff, pop_in;
   ptsch_pkg::cell_ctrl_type ctrl;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic [OW-1:0]            occ_ff, occ_in;
   logic [31:0]              next_id_ff, next_id_in;
   logic [CW-1:0]            cnt_ff, cnt_in, lim_ff, lim_in, popped_ff, popped_in;
   logic                     found_ff, found_in;

   ptsch_pkg::entry_type ent [DEPTH];
   logic                 le  [DEPTH];

   logic          out_free, accept, due0, due1, go;
   logic [CW-1:0] occ_wide;
   logic [15:0]   per1, fired_next;
   logic          retain;

   // Row of cells.
   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      ptsch_pkg::entry_type left_e, right_e;
      logic                 left_l;
      if (i == 0) begin : g_first
         assign left_e = ent[0];
         assign left_l = 1'b1;
      end else begin : g_mid
         assign left_e = ent[i-1];
         assign left_l = le[i-1];
      end
      if (i == DEPTH - 1) begin : g_last
         assign right_e = ent[i];
      end else begin : g_inner
         assign right_e = ent[i+1];
      end
      ptsch_cell #(.IDX(i), .OCC_W(OW)) u_cell (
         .clock      (clock),
         .ctrl       (ctrl),
         .occupancy  (occ_ff),
         .left_entry (left_e),
         .left_le    (left_l),
         .right_entry(right_e),
         .front_entry(ent[0]),
         .entry      (ent[i]),
         .le         (le[i])
      );
   end

   // Handshakes, status of the front of the row and repeat bookkeeping.
   assign out_free   = !rsp_valid_ff || rsp_ready;
   assign accept     = req_valid && req_ready;
   assign occ_wide   = CW'(occ_ff);
   assign due0       = (occ_ff != '0) && (ent[0].deadline <= req_ff.now);
   assign due1       = (occ_ff > OW'(1)) && (ent[1].deadline <= req_ff.now);
   assign go         = (popped_ff < lim_ff) && due0;
   assign per1       = (req_ff.period == 16'd0) ? 16'd1 : req_ff.period;
   assign fired_next = (pop_ff.fired == 16'hFFFF) ? pop_ff.fired : pop_ff.fired + 16'd1;
   assign retain     = (pop_ff.total == 16'd0) || (fired_next < pop_ff.total);

   assign req_ready = state_ff == ptsch_pkg::S_IDLE;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_ff;

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ptsch_pkg::S_IDLE: begin
            if (accept) begin
               case (req_word.req_type)
                  ptsch_pkg::REQ_ADD:    state_in = ptsch_pkg::S_ADD;
                  ptsch_pkg::REQ_REMOVE: state_in = ptsch_pkg::S_REM;
                  ptsch_pkg::REQ_TICK:   state_in = ptsch_pkg::S_TICK;
                  default:               state_in = ptsch_pkg::S_IDLE;
               endcase
            end
         end
         ptsch_pkg::S_ADD:     if (out_free) state_in = ptsch_pkg::S_IDLE;
         ptsch_pkg::S_REM:     if (cnt_ff == '0) state_in = ptsch_pkg::S_REM_RSP;
         ptsch_pkg::S_REM_RSP: if (out_free) state_in = ptsch_pkg::S_IDLE;
         ptsch_pkg::S_TICK: begin
            if (go) begin
               if (out_free) state_in = ptsch_pkg::S_REINS;
            end else if (popped_ff != '0 || out_free) begin
               state_in = ptsch_pkg::S_IDLE;
            end
         end
         ptsch_pkg::S_REINS:   state_in = ptsch_pkg::S_TICK;
         default:              state_in = ptsch_pkg::S_IDLE;
      endcase
   end

   // Datapath and cell commands.
   always_comb begin
      req_in       = req_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      pop_in       = pop_ff;
      occ_in       = occ_ff;
      next_id_in   = next_id_ff;
      cnt_in       = cnt_ff;
      lim_in       = lim_ff;
      popped_in    = popped_ff;
      found_in     = found_ff;
      ctrl.op      = ptsch_pkg::OP_HOLD;
      ctrl.x       = '{deadline: req_ff.first_now
                                 ? ptsch_pkg::sat_add(req_ff.now, req_ff.first_delay)
                                 : ptsch_pkg::sat_add(req_ff.now, per1),
                       id: next_id_ff, period: per1,
                       total: req_ff.repeat_total, fired: 16'd0};
      case (state_ff)
         ptsch_pkg::S_IDLE: begin
            if (accept) begin
               req_in    = req_word;
               cnt_in    = occ_wide;
               lim_in    = (occ_wide < MAXR_V) ? occ_wide : MAXR_V;
               popped_in = '0;
               found_in  = 1'b0;
            end
         end
         ptsch_pkg::S_ADD: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               if (occ_ff >= DEPTH_V) begin
                  rsp_in = '{resp_kind: ptsch_pkg::KIND_ADD, status: ptsch_pkg::ST_FULL,
                             timer_id: 32'd0, last: 1'b1};
               end else begin
                  ctrl.op    = ptsch_pkg::OP_INSERT;
                  occ_in     = occ_ff + OW'(1);
                  next_id_in = next_id_ff + 32'd1;
                  rsp_in = '{resp_kind: ptsch_pkg::KIND_ADD, status: ptsch_pkg::ST_OK,
                             timer_id: next_id_ff, last: 1'b1};
               end
            end
         end
         ptsch_pkg::S_REM: begin
            // Each step drops the first match or moves the front to the tail.
            if (cnt_ff != '0) begin
               cnt_in = cnt_ff - CW'(1);
               if (!found_ff && ent[0].id == req_ff.remove_id) begin
                  ctrl.op  = ptsch_pkg::OP_SHIFT;
                  occ_in   = occ_ff - OW'(1);
                  found_in = 1'b1;
               end else begin
                  ctrl.op = ptsch_pkg::OP_ROTATE;
               end
            end
         end
         ptsch_pkg::S_REM_RSP: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_in = '{resp_kind: ptsch_pkg::KIND_REMOVE,
                          status: found_ff ? ptsch_pkg::ST_OK : ptsch_pkg::ST_NOT_FOUND,
                          timer_id: req_ff.remove_id, last: 1'b1};
            end
         end
         ptsch_pkg::S_TICK: begin
            if (out_free) begin
               if (go) begin
                  // Pop the front timer and report it.
                  pop_in       = ent[0];
                  ctrl.op      = ptsch_pkg::OP_SHIFT;
                  occ_in       = occ_ff - OW'(1);
                  popped_in    = popped_ff + CW'(1);
                  rsp_valid_in = 1'b1;
                  rsp_in = '{resp_kind: ptsch_pkg::KIND_TICK, status: ptsch_pkg::ST_OK,
                             timer_id: ent[0].id,
                             last: (popped_ff + CW'(1) == lim_ff) || !due1};
               end else if (popped_ff == '0) begin
                  rsp_valid_in = 1'b1;
                  rsp_in = '{resp_kind: ptsch_pkg::KIND_TICK, status: ptsch_pkg::ST_NONE_DUE,
                             timer_id: 32'd0, last: 1'b1};
               end
            end
         end
         ptsch_pkg::S_REINS: begin
            // A popped timer with repeats left goes back in after every still-due timer.
            ctrl.x = '{deadline: ptsch_pkg::sat_add(req_ff.now, pop_ff.period),
                       id: pop_ff.id, period: pop_ff.period,
                       total: pop_ff.total,
                       fired: (pop_ff.total == 16'd0) ? pop_ff.fired : fired_next};
            if (retain) begin
               ctrl.op = ptsch_pkg::OP_INSERT;
               occ_in  = occ_ff + OW'(1);
            end
         end
         default: begin
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ptsch_pkg::S_IDLE;
         rsp_valid_ff <= 1'b0;
         occ_ff       <= '0;
         next_id_ff   <= 32'd1;
         cnt_ff       <= '0;
         lim_ff       <= '0;
         popped_ff    <= '0;
         found_ff     <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         occ_ff       <= occ_in;
         next_id_ff   <= next_id_in;
         cnt_ff       <= cnt_in;
         lim_ff       <= lim_in;
         popped_ff    <= popped_in;
         found_ff     <= found_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      req_ff <= req_in;
      rsp_ff <= rsp_in;
      pop_ff <= pop_in;
   end

   // Checks.
   a_occ_bound: assert property (@(posedge clock) disable iff (reset)
      occ_ff <= DEPTH_V) else $error("occupancy beyond depth");

   a_popped_bound: assert property (@(posedge clock) disable iff (reset)
      popped_ff <= lim_ff || state_ff == ptsch_pkg::S_IDLE)
      else $error("tick fired more timers than allowed");

   a_id_only_on_add: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ptsch_pkg::S_ADD) |=> (next_id_ff == $past(next_id_ff)))
      else $error("timer id advanced outside an add");

endmodule
`default_nettype wire
